// ----- rtl/lsbse_pkg.sv -----
// Package for the LSB steganography embed/extract block.
// Holds the header and position constants, status and register codes, and the config struct.
// No dependencies.
`default_nettype none

package lsbse_pkg;

   // Header length in channels and width of the channel position count.
   localparam int HEADER_BITS    = 32;
   localparam int POSITION_WIDTH = 28;

   // Register widths.
   localparam int LEN_W  = 32;
   localparam int CHAN_W = 28;

   // Width that holds 8 * length plus the header for any length value.
   localparam int CMP_W     = LEN_W + 4;
   localparam int HDR_IDX_W = $clog2(HEADER_BITS);

   // Saturated position value; an item there counts as beyond the image.
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   localparam logic [7:0] LSB_CLEAR_MASK = 8'hFE;
   localparam logic [2:0] LAST_BIT_IDX   = 3'd7;

   // Operating modes.
   localparam logic MODE_EMBED   = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;

   // Configuration port address width (three 32-bit registers).
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CSR_MODE           = 2'd0,
      CSR_MESSAGE_LENGTH = 2'd1,
      CSR_IMAGE_CHANNELS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_TOO_LARGE    = 2'd1,
      ST_EMPTY        = 2'd2,
      ST_INCONSISTENT = 2'd3
   } status_type;

   typedef struct packed {
      logic              mode;
      logic [LEN_W-1:0]  message_length;
      logic [CHAN_W-1:0] image_channels;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/lsb_stego_embed_extract.sv -----
// LSB image steganography, embed and extract: one image channel byte per beat.
// A result is registered in the output register in the cycle after its beat is accepted.
// Throughput: one beat per cycle; a result that is not taken holds off the next beat,
// which is then taken in the same cycle as that result.
// Reset (synchronous, active high) clears the config registers, the position count and stream state, and rsp_valid.
// Top level; depends on lsbse_pkg, lsbse_csr and lsbse_core.
`default_nettype none

module lsb_stego_embed_extract (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_channel_value,
   input  logic [7:0]                        req_message_byte,
   input  logic                              req_image_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_value,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last_byte,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lsbse_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import lsbse_pkg::*;

   cfg_type cfg;

   // Configuration registers.
   lsbse_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Channel datapath and result register.
   lsbse_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel_value (req_channel_value),
      .req_message_byte  (req_message_byte),
      .req_image_start   (req_image_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_last_byte     (rsp_last_byte)
   );

endmodule

`default_nettype wire

// ----- rtl/lsbse_csr.sv -----
// Configuration registers of the LSB steganography block behind an APB-style port.
// Depends on lsbse_pkg.
`default_nettype none

module lsbse_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lsbse_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output lsbse_pkg::cfg_type                 cfg
);
   import lsbse_pkg::*;

   logic              mode_ff, mode_in;
   logic [LEN_W-1:0]  msg_len_ff, msg_len_in;
   logic [CHAN_W-1:0] img_chan_ff, img_chan_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // Write decode: each register takes the beat addressed to it.
   always_comb begin
      mode_in     = mode_ff;
      msg_len_in  = msg_len_ff;
      img_chan_in = img_chan_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_MODE:           mode_in     = csr_pwdata[0];
            CSR_MESSAGE_LENGTH: msg_len_in  = csr_pwdata[LEN_W-1:0];
            CSR_IMAGE_CHANNELS: img_chan_in = csr_pwdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_EMBED;
         msg_len_ff  <= '0;
         img_chan_ff <= '0;
      end else begin
         mode_ff     <= mode_in;
         msg_len_ff  <= msg_len_in;
         img_chan_ff <= img_chan_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_idx)
         CSR_MODE:           csr_prdata = {31'd0, mode_ff};
         CSR_MESSAGE_LENGTH: csr_prdata = msg_len_ff;
         CSR_IMAGE_CHANNELS: csr_prdata = {{(32 - CHAN_W){1'b0}}, img_chan_ff};
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.mode           = mode_ff;
   assign cfg.message_length = msg_len_ff;
   assign cfg.image_channels = img_chan_ff;

endmodule

`default_nettype wire

// ----- rtl/lsbse_core.sv -----
// Per-channel datapath of the LSB steganography block: position count, LSB replace,
// header and message bit collection, and the result register. Depends on lsbse_pkg.
`default_nettype none

module lsbse_core (
   input  logic                clock,
   input  logic                reset,
   input  lsbse_pkg::cfg_type  cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_channel_value,
   input  logic [7:0]          req_message_byte,
   input  logic                req_image_start,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_value,
   output logic [1:0]          rsp_status,
   output logic                rsp_last_byte
);
   import lsbse_pkg::*;

   // Stream state.
   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic [HEADER_BITS-1:0]    len_shift_ff, len_shift_in;
   logic [7:0]                byte_shift_ff, byte_shift_in;
   logic                      failed_ff, failed_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] value_ff, value_in;
   status_type status_ff, status_in;
   logic       last_ff, last_in;

   logic                      accept;
   logic                      emit;
   logic [POSITION_WIDTH-1:0] pos;
   logic [POSITION_WIDTH-1:0] off;
   logic [HEADER_BITS-1:0]    len_shift;
   logic [HEADER_BITS-1:0]    len_next;
   logic [7:0]                byte_shift;
   logic [7:0]                byte_next;
   logic                      failed;
   logic                      at_max;
   logic                      in_header;
   logic [CMP_W-1:0]          need;
   logic [CMP_W-1:0]          msg_bits;
   logic [CMP_W-1:0]          ext_bits;
   logic [CMP_W-1:0]          cap;
   logic                      too_large;
   status_type                embed_status;
   logic                      in_msg;
   logic                      ext_in_msg;
   logic                      ext_last;
   logic                      small_image;
   logic                      bad_length;
   logic [HDR_IDX_W-1:0]      hdr_idx;
   logic                      hdr_bit;
   logic                      msg_bit;
   logic [7:0]                embed_value;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // An image start clears the stream state before this beat is used.
   assign pos        = req_image_start ? '0 : position_ff;
   assign len_shift  = req_image_start ? '0 : len_shift_ff;
   assign byte_shift = req_image_start ? '0 : byte_shift_ff;
   assign failed     = req_image_start ? 1'b0 : failed_ff;

   assign at_max    = (pos == POS_MAX);
   assign in_header = CMP_W'(pos) < CMP_W'(HEADER_BITS);
   assign off       = pos - POSITION_WIDTH'(HEADER_BITS);

   // Embed: capacity check on the configured length.
   assign need      = CMP_W'(HEADER_BITS) + CMP_W'({cfg.message_length, 3'b000});
   assign too_large = ((cfg.message_length >> HEADER_BITS) != '0) ||
                      (need > CMP_W'(cfg.image_channels));
   assign embed_status = too_large ? ST_TOO_LARGE :
                         (cfg.message_length == '0) ? ST_EMPTY : ST_OK;

   // Embed: pick the header bit or the message bit for this channel.
   assign msg_bits = CMP_W'({cfg.message_length, 3'b000});
   assign in_msg   = CMP_W'(off) < msg_bits;
   assign hdr_idx  = HDR_IDX_W'(HEADER_BITS - 1) - pos[HDR_IDX_W-1:0];
   assign hdr_bit  = cfg.message_length[hdr_idx];
   assign msg_bit  = req_message_byte[LAST_BIT_IDX - off[2:0]];

   always_comb begin
      embed_value = req_channel_value;
      if (embed_status == ST_OK && !at_max) begin
         if (in_header) begin
            embed_value = (req_channel_value & LSB_CLEAR_MASK) | {7'd0, hdr_bit};
         end else if (in_msg) begin
            embed_value = (req_channel_value & LSB_CLEAR_MASK) | {7'd0, msg_bit};
         end
      end
   end

   // Extract: header collection and length check against the capacity.
   assign len_next    = {len_shift[HEADER_BITS-2:0], req_channel_value[0]};
   assign small_image = CMP_W'(cfg.image_channels) < CMP_W'(HEADER_BITS);
   assign cap         = CMP_W'(cfg.image_channels) - CMP_W'(HEADER_BITS);
   assign bad_length  = small_image || (CMP_W'({len_next, 3'b000}) > cap);
   assign ext_bits    = CMP_W'({len_shift, 3'b000});
   assign ext_in_msg  = CMP_W'(off) < ext_bits;
   assign ext_last    = (CMP_W'(off) + CMP_W'(1)) == ext_bits;
   assign byte_next   = {byte_shift[6:0], req_channel_value[0]};

   // Next state and result for the accepted beat.
   always_comb begin
      position_in   = position_ff;
      len_shift_in  = len_shift_ff;
      byte_shift_in = byte_shift_ff;
      failed_in     = failed_ff;
      emit          = 1'b0;
      value_in      = value_ff;
      status_in     = status_ff;
      last_in       = last_ff;
      if (accept) begin
         position_in   = at_max ? POS_MAX : pos + POSITION_WIDTH'(1);
         len_shift_in  = len_shift;
         byte_shift_in = byte_shift;
         failed_in     = failed;
         if (cfg.mode == MODE_EMBED) begin
            emit      = 1'b1;
            value_in  = embed_value;
            status_in = embed_status;
            last_in   = 1'b0;
         end else if (!failed && !at_max) begin
            if (in_header) begin
               if (pos == '0 && small_image) begin
                  failed_in = 1'b1;
                  emit      = 1'b1;
                  value_in  = '0;
                  status_in = ST_INCONSISTENT;
                  last_in   = 1'b0;
               end else begin
                  len_shift_in = len_next;
                  if (pos == POSITION_WIDTH'(HEADER_BITS - 1) && bad_length) begin
                     failed_in = 1'b1;
                     emit      = 1'b1;
                     value_in  = '0;
                     status_in = ST_INCONSISTENT;
                     last_in   = 1'b0;
                  end
               end
            end else if (ext_in_msg) begin
               byte_shift_in = byte_next;
               if (off[2:0] == LAST_BIT_IDX) begin
                  emit          = 1'b1;
                  value_in      = byte_next;
                  status_in     = ST_OK;
                  last_in       = ext_last;
                  byte_shift_in = '0;
               end
            end
         end
      end
   end

   // The result register frees up when its beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         len_shift_ff  <= '0;
         byte_shift_ff <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         position_ff   <= position_in;
         len_shift_ff  <= len_shift_in;
         byte_shift_ff <= byte_shift_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = value_ff;
   assign rsp_status    = status_ff;
   assign rsp_last_byte = last_ff;

   // The position advances by one per beat within an image until it saturates.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_image_start && position_ff != POS_MAX
      |=> position_ff == $past(position_ff) + POSITION_WIDTH'(1))
      else $error("position did not advance by one");

   // The position holds once saturated.
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      accept && !req_image_start && position_ff == POS_MAX |=> position_ff == POS_MAX)
      else $error("saturated position moved");

   // A pending length error always comes with the failed flag set.
   a_fail_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_INCONSISTENT |-> failed_ff)
      else $error("length error without failed flag");

   // Only a good extracted byte may carry the last marker.
   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> status_ff == ST_OK)
      else $error("last marker on an error result");

endmodule

`default_nettype wire
